>>> rtl/core/usfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usfm_pkg
// Shared types, constants and helper functions of the UTF-8 first-match
// substring search: beat layouts, register indexes and counter arithmetic.
// ----------------------------------------------------------------------------
package usfm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int COUNT_W     = 16;
  localparam int POS_W       = 16;
  localparam int PTR_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int PLEN_W      = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_CHAR     = 2'd1;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [PTR_W-1:0]   ptr_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic [5:0] pattern_index;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic matched;
    pos_t char_position;
    pos_t byte_offset;
  } out_beat_t;

  typedef struct packed {
    logic wr;
    logic step;
    logic clr;
    logic lead_up;
    logic lead_down;
  } cell_ctrl_t;

  localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

  function automatic logic starts_char(logic [7:0] b);
    return b[7:6] != 2'b10;
  endfunction

  function automatic count_t sat_inc(count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

  function automatic pos_t clamp_pos(count_t v);
    logic [COUNT_W+POS_W-1:0] wide;
    logic [COUNT_W+POS_W-1:0] lim;
    wide = {{POS_W{1'b0}}, v};
    lim  = {{COUNT_W{1'b0}}, {POS_W{1'b1}}};
    return (wide > lim) ? {POS_W{1'b1}} : wide[POS_W-1:0];
  endfunction

endpackage

>>> rtl/core/usfm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usfm_cell
// One pattern position: holds a pattern byte, its lead flag, the lead count
// of the pattern prefix ending here, and the prefix-hit bit of the chain.
// ----------------------------------------------------------------------------
module usfm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  usfm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          data_byte,
  input  logic                prev_hit,
  output logic                hit,
  output logic                hit_now,
  output logic                lead,
  output usfm_pkg::len_t      lead_count
);
  import usfm_pkg::*;

  logic [7:0] pat_r;
  logic       hit_r;
  logic       hit_nxt;
  logic       lead_r;
  logic       lead_nxt;
  len_t       lead_count_r;
  len_t       lead_count_nxt;

  always_comb begin
    hit_now = prev_hit && (data_byte == pat_r);
    if (ctrl.clr) begin
      hit_nxt = 1'b0;
    end else if (ctrl.step) begin
      hit_nxt = hit_now;
    end else begin
      hit_nxt = hit_r;
    end
    lead_nxt = ctrl.wr ? starts_char(data_byte) : lead_r;
    if (ctrl.lead_up) begin
      lead_count_nxt = lead_count_r + len_t'(1);
    end else if (ctrl.lead_down) begin
      lead_count_nxt = lead_count_r - len_t'(1);
    end else begin
      lead_count_nxt = lead_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r        <= 1'b0;
      lead_r       <= 1'b0;
      lead_count_r <= '0;
    end else begin
      hit_r        <= hit_nxt;
      lead_r       <= lead_nxt;
      lead_count_r <= lead_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      pat_r <= data_byte;
    end
  end

  assign hit        = hit_r;
  assign lead       = lead_r;
  assign lead_count = lead_count_r;

endmodule

>>> rtl/core/usfm_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usfm_outbuf
// Result register with a skid stage, so that a new beat is taken while a
// finished result still waits on the output.
// ----------------------------------------------------------------------------
module usfm_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  usfm_pkg::out_beat_t  res_beat,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output usfm_pkg::out_beat_t  out_beat
);
  import usfm_pkg::*;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_beat_t out_beat_r;
  out_beat_t out_beat_nxt;
  logic      skid_valid_r;
  logic      skid_valid_nxt;
  out_beat_t skid_beat_r;
  out_beat_t skid_beat_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_beat_nxt   = out_beat_r;
    skid_valid_nxt = skid_valid_r;
    skid_beat_nxt  = skid_beat_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_beat_nxt   = skid_beat_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_beat_nxt  = res_beat;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_beat_nxt  = res_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_beat_r  <= out_beat_nxt;
    skid_beat_r <= skid_beat_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

>>> rtl/core/utf8_substring_first_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_substring_first_match
// Streaming first-occurrence search of a byte pattern in UTF-8 text.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle, both pattern writes and text
// bytes; a result is registered in the output register, or in the skid
// stage while the output stalls. The input stalls only while a second
// result waits there behind one that the output has not yet taken. A row of
// MAX_PATTERN cells holds the pattern and one prefix-hit bit per pattern
// position, so every character-aligned candidate advances in the same
// cycle; the byte compare in each cell followed by the selection of the
// last pattern position sets the cycle time. Each text gives exactly one
// result: at the first match, or at its final byte.
module utf8_substring_first_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  usfm_pkg::in_beat_t            in_beat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output usfm_pkg::out_beat_t           out_beat,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [usfm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [usfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import usfm_pkg::*;

  logic [PLEN_W-1:0] pattern_length_r;
  logic [15:0]       start_char_r;
  count_t            bytes_r;
  count_t            bytes_nxt;
  count_t            chars_r;
  count_t            chars_nxt;
  logic [15:0]       chars_before_r;
  logic [15:0]       chars_before_nxt;
  logic              started_r;
  logic              started_nxt;
  logic              reported_r;
  logic              reported_nxt;

  logic              accept;
  logic              text_beat;
  logic              pat_wr;
  logic              lead;
  logic              begin_now;
  logic              step;
  logic              match;
  logic              eot;
  len_t              len;
  ptr_t              last_ptr;
  ptr_t              wr_ptr;
  len_t              leads;
  count_t            cur_chars;
  count_t            cpos;
  count_t            bpos;
  count_t            len_m1;
  logic              old_lead;
  logic              new_lead;
  logic              empty_ok;
  logic              res_valid;
  out_beat_t         res_beat;
  logic              buf_full;

  cell_ctrl_t        ctrl_vec [MAX_PATTERN];
  logic              hit_vec [MAX_PATTERN];
  logic              hit_now_vec [MAX_PATTERN];
  logic              lead_vec [MAX_PATTERN];
  len_t              lead_count_vec [MAX_PATTERN];

  assign accept    = in_valid && !in_stall;
  assign text_beat = accept && (in_beat.command == CMD_TEXT);
  assign pat_wr    = accept && (in_beat.command == CMD_PATTERN) &&
                     (int'(in_beat.pattern_index) < MAX_PATTERN);
  assign eot       = text_beat && in_beat.end_of_text;
  assign lead      = starts_char(in_beat.data_byte);
  assign wr_ptr    = ptr_t'(in_beat.pattern_index);
  assign old_lead  = lead_vec[wr_ptr];
  assign new_lead  = lead;

  assign len = (int'(pattern_length_r) > MAX_PATTERN) ? len_t'(MAX_PATTERN) :
               len_t'(pattern_length_r);
  assign last_ptr = ptr_t'(len - len_t'(1));
  assign leads    = lead_count_vec[last_ptr];
  assign len_m1   = count_t'(len) - count_t'(1);

  assign begin_now = !reported_r && !started_r &&
                     ((start_char_r == 16'd0) || (lead && chars_before_r == start_char_r));
  assign step      = text_beat && !reported_r && (started_r || begin_now);
  assign match     = step && (len != '0) && hit_now_vec[last_ptr];
  assign cur_chars = lead ? sat_inc(chars_r) : chars_r;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev_hit;
    logic in_tail;
    if (k == 0) begin : g_head
      assign prev_hit = lead;
    end else begin : g_link
      assign prev_hit = hit_vec[k-1];
    end
    assign in_tail              = pat_wr && (int'(wr_ptr) <= k);
    assign ctrl_vec[k].wr        = pat_wr && (int'(wr_ptr) == k);
    assign ctrl_vec[k].step      = step;
    assign ctrl_vec[k].clr       = eot;
    assign ctrl_vec[k].lead_up   = in_tail && new_lead && !old_lead;
    assign ctrl_vec[k].lead_down = in_tail && !new_lead && old_lead;

    usfm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl_vec[k]),
      .data_byte  (in_beat.data_byte),
      .prev_hit   (prev_hit),
      .hit        (hit_vec[k]),
      .hit_now    (hit_now_vec[k]),
      .lead       (lead_vec[k]),
      .lead_count (lead_count_vec[k])
    );
  end

  always_comb begin
    if (cur_chars == COUNT_MAX) begin
      cpos = COUNT_MAX;
    end else if (cur_chars >= count_t'(leads)) begin
      cpos = cur_chars - count_t'(leads);
    end else begin
      cpos = '0;
    end
    if (bytes_r == COUNT_MAX) begin
      bpos = COUNT_MAX;
    end else if (bytes_r >= len_m1) begin
      bpos = bytes_r - len_m1;
    end else begin
      bpos = '0;
    end
  end

  always_comb begin
    started_nxt      = started_r;
    reported_nxt     = reported_r;
    bytes_nxt        = bytes_r;
    chars_nxt        = chars_r;
    chars_before_nxt = chars_before_r;
    if (text_beat && !reported_r && !started_r) begin
      if (begin_now) begin
        started_nxt = 1'b1;
      end else if (lead && chars_before_r != 16'hFFFF) begin
        chars_before_nxt = chars_before_r + 16'd1;
      end
    end
    if (step) begin
      bytes_nxt = sat_inc(bytes_r);
      chars_nxt = cur_chars;
    end
    if (match) begin
      reported_nxt = 1'b1;
    end
    empty_ok = (len == '0) && (started_nxt || chars_before_nxt == start_char_r);
    res_valid = match || (eot && !reported_r);
    if (match) begin
      res_beat.matched       = 1'b1;
      res_beat.char_position = clamp_pos(cpos);
      res_beat.byte_offset   = clamp_pos(bpos);
    end else begin
      res_beat.matched       = empty_ok;
      res_beat.char_position = '0;
      res_beat.byte_offset   = '0;
    end
    if (eot) begin
      started_nxt      = 1'b0;
      reported_nxt     = 1'b0;
      bytes_nxt        = '0;
      chars_nxt        = '0;
      chars_before_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= '0;
      start_char_r     <= '0;
      bytes_r          <= '0;
      chars_r          <= '0;
      chars_before_r   <= '0;
      started_r        <= 1'b0;
      reported_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN_LENGTH: pattern_length_r <= cfg_data[PLEN_W-1:0];
          CFG_START_CHAR:     start_char_r     <= cfg_data[15:0];
          default: ;
        endcase
      end
      bytes_r        <= bytes_nxt;
      chars_r        <= chars_nxt;
      chars_before_r <= chars_before_nxt;
      started_r      <= started_nxt;
      reported_r     <= reported_nxt;
    end
  end

  usfm_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_beat  (res_beat),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  assign in_stall  = buf_full;
  assign cfg_ready = 1'b1;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid stage holds a beat while the output is empty");

  a_match_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (match && !eot) |=> reported_r)
    else $error("match was not recorded as reported");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (bytes_r == '0 && chars_r == '0))
    else $error("search counters moved before the search began");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (reported_r && !eot) |-> !res_valid)
    else $error("second result for one text");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 first-match substring search. After
// reset the whole pattern store is loaded. A short table of directed beats
// and register writes follows, then random phases of patterns and texts.
// A behavioral copy of the search predicts the results the table lacks;
// all are compared field by field, in order, while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import usfm_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS   = 1000;
  localparam int DIR_ROWS       = 29;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_INDEX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0]   reg_value;
    in_beat_t                beat;
    logic                    typed;
    out_beat_t               want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_beat_t               in_beat;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_beat_t              out_beat;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [7:0]             pat_mem [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit_row;
  count_t                 text_bytes;
  count_t                 text_chars;
  count_t                 skipped_chars;
  logic                   in_search;
  logic                   found_flag;
  logic [PLEN_W-1:0]      len_reg;
  logic [15:0]            start_reg;

  out_beat_t              pending_reports [$];
  out_beat_t              head_report;
  logic [7:0]             text_q [$];
  int                     err_count   = 0;
  int                     beat_count  = 0;
  int                     quiet_cycles = 0;
  int                     in_gap_max  = 8;
  int                     out_gap_max = 8;
  int                     out_hold    = 0;
  int                     taken_count = 0;
  int                     seen_count  = 0;

  utf8_substring_first_match DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic in_beat_t make_beat(logic cmd, int val, int idx, logic eot);
    in_beat_t b;
    b.command       = cmd;
    b.data_byte     = 8'(val);
    b.pattern_index = 6'(idx);
    b.end_of_text   = eot;
    return b;
  endfunction

  function automatic dir_row_t row_reg(logic [CFG_INDEX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind      = ROW_REG;
    r.reg_index = idx;
    r.reg_value = v;
    return r;
  endfunction

  function automatic dir_row_t row_pat(int idx, int v, logic eot);
    dir_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.beat = make_beat(CMD_PATTERN, v, idx, eot);
    return r;
  endfunction

  function automatic dir_row_t row_txt(int v, logic eot);
    dir_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.beat = make_beat(CMD_TEXT, v, 0, eot);
    return r;
  endfunction

  function automatic dir_row_t row_res(int v, logic m, int c, int bo);
    dir_row_t r;
    r = '0;
    r.kind               = ROW_BEAT;
    r.beat               = make_beat(CMD_TEXT, v, 63, 1'b1);
    r.typed              = 1'b1;
    r.want.matched       = m;
    r.want.char_position = 16'(c);
    r.want.byte_offset   = 16'(bo);
    return r;
  endfunction

  function automatic void forget_text();
    hit_row       = '0;
    text_bytes    = '0;
    text_chars    = '0;
    skipped_chars = '0;
    in_search     = 1'b0;
    found_flag    = 1'b0;
  endfunction

  // Advances the search by one beat; returns 1 when the beat yields a result.
  function automatic logic search_byte(input in_beat_t b, output out_beat_t res);
    int                     eff_len;
    int                     leads;
    int                     cur;
    logic                   lead;
    logic                   got;
    logic [MAX_PATTERN-1:0] next_hits;
    eff_len = (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);
    lead    = (b.data_byte[7:6] != 2'b10);
    res     = '0;
    got     = 1'b0;
    if (b.command == CMD_PATTERN) begin
      pat_mem[b.pattern_index] = b.data_byte;
      return 1'b0;
    end
    if (!found_flag) begin
      if (!in_search) begin
        if (start_reg == 0 || (lead && skipped_chars == start_reg)) begin
          in_search = 1'b1;
        end else if (lead && skipped_chars != COUNT_MAX) begin
          skipped_chars++;
        end
      end
      if (in_search) begin
        cur = (lead && text_chars != COUNT_MAX) ? int'(text_chars) + 1 : int'(text_chars);
        for (int k = 0; k < MAX_PATTERN; k++) begin
          next_hits[k] = ((k == 0) ? lead : hit_row[k-1]) && (b.data_byte == pat_mem[k]);
        end
        hit_row = next_hits;
        if (eff_len > 0 && hit_row[eff_len-1]) begin
          leads = 0;
          for (int i = 0; i < eff_len; i++) begin
            if (pat_mem[i][7:6] != 2'b10) leads++;
          end
          res.matched = 1'b1;
          if (cur == int'(COUNT_MAX)) begin
            res.char_position = COUNT_MAX;
          end else begin
            res.char_position = (cur >= leads) ? 16'(cur - leads) : 16'd0;
          end
          if (text_bytes == COUNT_MAX) begin
            res.byte_offset = COUNT_MAX;
          end else if (int'(text_bytes) >= eff_len - 1) begin
            res.byte_offset = 16'(int'(text_bytes) - eff_len + 1);
          end else begin
            res.byte_offset = 16'd0;
          end
          found_flag = 1'b1;
          got        = 1'b1;
        end
        if (text_bytes != COUNT_MAX) text_bytes++;
        text_chars = 16'(cur);
      end
    end
    if (b.end_of_text) begin
      if (!found_flag) begin
        res.matched = (eff_len == 0) && (in_search || skipped_chars == start_reg);
        got         = 1'b1;
      end
      forget_text();
    end
    return got;
  endfunction

  // One UTF-8 character, first byte in the low bits; some are broken on purpose.
  function automatic logic [31:0] pick_char(output int n);
    case ($urandom_range(0, 9))
      0, 1, 2: begin n = 1; return 32'h0000_0061; end
      3, 4:    begin n = 1; return 32'h0000_0062; end
      5:       begin n = 2; return 32'h0000_A9C3; end
      6:       begin n = 3; return 32'h00AC_82E2; end
      7:       begin n = 4; return 32'h8098_9FF0; end
      8:       begin n = 1; return 32'($urandom_range(0, 255)); end
      default: begin n = 2; return 32'h0000_61C3; end
    endcase
  endfunction

  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    int        gap;
    out_beat_t res;
    logic      got;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    got = search_byte(b, res);
    if (typed) begin
      pending_reports.push_back(want);
    end else if (got) begin
      pending_reports.push_back(res);
    end
    beat_count++;
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PATTERN_LENGTH) begin
      len_reg = val[PLEN_W-1:0];
    end else if (idx == CFG_START_CHAR) begin
      start_reg = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with no prediction pending");
        err_count++;
      end else begin
        head_report = pending_reports.pop_front();
        if (out_beat.matched !== head_report.matched) begin
          $error("matched: expected %0d, got %0d", head_report.matched, out_beat.matched);
          err_count++;
        end
        if (out_beat.char_position !== head_report.char_position) begin
          $error("char_position: expected %0d, got %0d",
                 head_report.char_position, out_beat.char_position);
          err_count++;
        end
        if (out_beat.byte_offset !== head_report.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d",
                 head_report.byte_offset, out_beat.byte_offset);
          err_count++;
        end
      end
      taken_count++;
    end
  end

  always @(negedge clk) begin
    if (seen_count != taken_count) begin
      seen_count = taken_count;
      out_hold   = $urandom_range(0, out_gap_max);
    end
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    dir_row_t          rows [DIR_ROWS];
    int                base;
    int                eff_len;
    int                n_chars;
    int                ins_at;
    int                pos;
    int                n;
    logic [31:0]       ch;
    logic              noise_text;
    logic [PLEN_W-1:0] plen_pick;
    logic [15:0]       start_pick;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_beat   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    len_reg   = '0;
    start_reg = '0;
    forget_text();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < MAX_PATTERN; i++) begin
      send_beat(make_beat(CMD_PATTERN, $urandom_range(0, 255), i, 1'($urandom_range(0, 1))),
                1'b0, '0);
    end

    rows = '{
      row_res(8'h41, 1'b1, 0, 0),
      row_pat(0, 8'h00, 1'b1),
      row_pat(1, 8'hFF, 1'b0),
      row_pat(63, 8'hC3, 1'b1),
      row_reg(CFG_PATTERN_LENGTH, 16'd2),
      row_txt(8'h80, 1'b0),
      row_txt(8'h00, 1'b0),
      row_txt(8'hFF, 1'b0),
      row_txt(8'h41, 1'b1),
      row_reg(CFG_START_CHAR, 16'd5),
      row_txt(8'h00, 1'b0),
      row_res(8'hFF, 1'b0, 0, 0),
      row_reg(CFG_PATTERN_LENGTH, 16'd0),
      row_reg(CFG_START_CHAR, 16'd2),
      row_txt(8'h61, 1'b0),
      row_res(8'h62, 1'b1, 0, 0),
      row_reg(CFG_PATTERN_LENGTH, 16'hFFFF),
      row_reg(CFG_START_CHAR, 16'd0),
      row_txt(8'h00, 1'b0),
      row_txt(8'hFF, 1'b0),
      row_res(8'h41, 1'b0, 0, 0),
      row_reg(CFG_PATTERN_LENGTH, 16'd3),
      row_reg(CFG_START_CHAR, 16'd1),
      row_txt(8'h7F, 1'b0),
      row_txt(8'h00, 1'b0),
      row_pat(2, 8'h80, 1'b0),
      row_txt(8'hFF, 1'b0),
      row_txt(8'h80, 1'b0),
      row_txt(8'h80, 1'b1)
    };
    foreach (rows[r]) begin
      if (rows[r].kind == ROW_REG) begin
        settle_idle();
        write_reg(rows[r].reg_index, rows[r].reg_value);
      end else begin
        send_beat(rows[r].beat, rows[r].typed, rows[r].want);
      end
    end

    base = beat_count;
    while (beat_count - base < RANDOM_BEATS) begin
      settle_idle();
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      case ($urandom_range(0, 9))
        0:       plen_pick = 7'd0;
        1:       plen_pick = 7'(MAX_PATTERN);
        2:       plen_pick = 7'($urandom_range(MAX_PATTERN + 1, 127));
        3:       plen_pick = 7'($urandom_range(7, 20));
        default: plen_pick = 7'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: start_pick = 16'd0;
        5, 6, 7:       start_pick = 16'($urandom_range(1, 3));
        8:             start_pick = 16'hFFFF;
        default:       start_pick = 16'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_PATTERN_LENGTH, {9'($urandom), plen_pick});
      write_reg(CFG_START_CHAR, start_pick);
      eff_len = (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);

      if ($urandom_range(0, 3) != 0) begin
        pos = 0;
        while (pos < eff_len) begin
          ch = pick_char(n);
          for (int j = 0; j < n && pos < eff_len; j++) begin
            send_beat(make_beat(CMD_PATTERN, ch[8*j +: 8], pos, 1'($urandom_range(0, 1))),
                      1'b0, '0);
            pos++;
          end
        end
      end

      repeat ($urandom_range(2, 5)) begin
        text_q.delete();
        noise_text = ($urandom_range(0, 7) == 0);
        n_chars    = $urandom_range(0, 12);
        ins_at     = ($urandom_range(0, 4) != 0) ? $urandom_range(0, n_chars) : -1;
        for (int c = 0; c <= n_chars; c++) begin
          if (c == ins_at) begin
            for (int i = 0; i < eff_len; i++) text_q.push_back(pat_mem[i]);
          end
          if (c < n_chars) begin
            if (noise_text) begin
              text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
              ch = pick_char(n);
              for (int j = 0; j < n; j++) text_q.push_back(ch[8*j +: 8]);
            end
          end
        end
        if (text_q.size() == 0) text_q.push_back(8'h61);
        foreach (text_q[i]) begin
          if ($urandom_range(0, 15) == 0) begin
            send_beat(make_beat(CMD_PATTERN, $urandom_range(0, 255), $urandom_range(0, 63),
                                1'($urandom_range(0, 1))), 1'b0, '0);
          end
          send_beat(make_beat(CMD_TEXT, text_q[i], $urandom_range(0, 63),
                              i == text_q.size() - 1), 1'b0, '0);
        end
      end
    end

    settle_idle();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/usfm_pkg.sv
rtl/core/usfm_cell.sv
rtl/core/usfm_outbuf.sv
rtl/core/utf8_substring_first_match.sv
bench/tb_top.sv
